// ===== rtl/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and character helpers for the integer to ascii
// formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

   localparam int VALUE_WIDTH = 32;

   // decimal digits needed for the largest value, hex digits for the full width
   localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int HEX_W      = 4 * HEX_DIGITS;
   localparam int DIG_W      = BCD_W;
   localparam int CNT_W      = $clog2(BCD_DIGITS + 1);
   localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);

   localparam int OPCODE_W   = 2;
   localparam int REQ_BITS   = OPCODE_W + VALUE_WIDTH;
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8;
   localparam int CHAR_W     = 7;
   localparam int RSP_W      = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   typedef enum logic [OPCODE_W-1:0] {
      OP_HEX          = 2'd0,
      OP_SIGNED_DEC   = 2'd1,
      OP_UNSIGNED_DEC = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SKIP = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] mag;
   } conv_req_type;

   typedef struct packed {
      logic             done;
      logic [BCD_W-1:0] bcd;
   } conv_rsp_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      unique case (d)
         4'h0: c = 7'h30;
         4'h1: c = 7'h31;
         4'h2: c = 7'h32;
         4'h3: c = 7'h33;
         4'h4: c = 7'h34;
         4'h5: c = 7'h35;
         4'h6: c = 7'h36;
         4'h7: c = 7'h37;
         4'h8: c = 7'h38;
         4'h9: c = 7'h39;
         4'hA: c = 7'h41;
         4'hB: c = 7'h42;
         4'hC: c = 7'h43;
         4'hD: c = 7'h44;
         4'hE: c = 7'h45;
         default: c = 7'h46;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] dec_char(input logic [3:0] d);
      return CHAR_ZERO + {3'b000, d};
   endfunction

endpackage

// ===== rtl/i2a_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// i2a_bcd_conv
// Bit-serial binary to bcd converter: one input bit per cycle, shift and
// add-3 on every decimal digit.
// ----------------------------------------------------------------------------
module i2a_bcd_conv (
   input  logic                 clock,
   input  logic                 reset,
   input  i2a_pkg::conv_req_type conv_req,
   output i2a_pkg::conv_rsp_type conv_rsp
);

   logic [i2a_pkg::VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [i2a_pkg::BCD_W-1:0]       bcd_ff, bcd_in;
   logic [i2a_pkg::BCD_W-1:0]       bcd_adj;
   logic [i2a_pkg::BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   // digits of five or more get three added before the shift
   always_comb begin
      logic [3:0] nib;
      nib = 4'd0;
      for (int i = 0; i < i2a_pkg::BCD_DIGITS; i++) begin
         nib = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (conv_req.start) begin
         bin_in  = conv_req.mag;
         bcd_in  = '0;
         cnt_in  = i2a_pkg::BIT_CNT_W'(i2a_pkg::VALUE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {bcd_adj[i2a_pkg::BCD_W-2:0], bin_ff[i2a_pkg::VALUE_WIDTH-1]};
         bin_in = {bin_ff[i2a_pkg::VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == i2a_pkg::BIT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign conv_rsp.done = done_ff;
   assign conv_rsp.bcd  = bcd_ff;

endmodule

// ===== rtl/integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one integer as a run of ascii characters, most significant first.
// ----------------------------------------------------------------------------
// The req channel carries one word per number: opcode (hex, signed decimal,
// unsigned decimal) and the raw value. The rsp channel returns one word per
// character, with tlast on the final character of the number.
// Hex mode: 8 digits; a taken word goes to the emit state, which loads the
// first digit into the output register. Decimal modes: the value goes through
// a bit-serial binary to bcd converter, one bit per cycle, then leading zeros
// are dropped one digit per cycle (up to 9), then the sign and digits leave
// one per cycle while the receiver keeps up. One number is in flight at a
// time; req_tready is high only while the block is free, and a new word can
// be taken while the last character still waits in the output register.
// A stalled receiver holds the output register and pauses the character
// sequence without losing anything. Reset drops any number in progress and
// clears the output valid.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [i2a_pkg::REQ_W-1:0]  req_tdata,  // opcode[1:0], value[33:2], zeros
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [i2a_pkg::RSP_W-1:0]  rsp_tdata,  // character[6:0], zero[7]
   output logic                       rsp_tlast
);

   i2a_pkg::state_type              state_ff, state_in;
   logic [i2a_pkg::DIG_W-1:0]       digits_ff, digits_in;
   logic [i2a_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            neg_ff, neg_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [i2a_pkg::CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            hex_mode_ff, hex_mode_in;

   i2a_pkg::conv_req_type           conv_req;
   i2a_pkg::conv_rsp_type           conv_rsp;

   logic [i2a_pkg::OPCODE_W-1:0]    opcode;
   logic [i2a_pkg::VALUE_WIDTH-1:0] value;
   logic                            value_neg;
   logic                            req_fire;
   logic                            out_free;
   logic [3:0]                      top_digit;

   assign opcode     = req_tdata[i2a_pkg::OPCODE_W-1:0];
   assign value      = req_tdata[i2a_pkg::REQ_BITS-1:i2a_pkg::OPCODE_W];
   assign value_neg  = (opcode == i2a_pkg::OP_SIGNED_DEC) &&
                       value[i2a_pkg::VALUE_WIDTH-1];
   assign req_tready = (state_ff == i2a_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign top_digit  = digits_ff[i2a_pkg::DIG_W-1 -: 4];

   // two's complement negate also covers the most negative value
   assign conv_req.start = req_fire && (opcode != i2a_pkg::OP_HEX);
   assign conv_req.mag   = value_neg ? (~value + 1'b1) : value;

   i2a_bcd_conv u_bcd_conv (
      .clock    (clock),
      .reset    (reset),
      .conv_req (conv_req),
      .conv_rsp (conv_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      hex_mode_in  = hex_mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (req_fire) begin
               neg_in = value_neg;
               if (opcode == i2a_pkg::OP_HEX) begin
                  hex_mode_in = 1'b1;
                  digits_in   = i2a_pkg::DIG_W'(i2a_pkg::HEX_W'(value))
                                << (i2a_pkg::DIG_W - i2a_pkg::HEX_W);
                  cnt_in      = i2a_pkg::CNT_W'(i2a_pkg::HEX_DIGITS);
                  state_in    = i2a_pkg::ST_EMIT;
               end else begin
                  hex_mode_in = 1'b0;
                  state_in    = i2a_pkg::ST_CONV;
               end
            end
         end
         i2a_pkg::ST_CONV: begin
            if (conv_rsp.done) begin
               digits_in = conv_rsp.bcd;
               cnt_in    = i2a_pkg::CNT_W'(i2a_pkg::BCD_DIGITS);
               state_in  = i2a_pkg::ST_SKIP;
            end
         end
         i2a_pkg::ST_SKIP: begin
            // drop leading zeros but keep at least one digit
            if ((top_digit == 4'd0) && (cnt_ff != i2a_pkg::CNT_W'(1))) begin
               digits_in = digits_ff << 4;
               cnt_in    = cnt_ff - 1'b1;
            end else begin
               state_in = i2a_pkg::ST_EMIT;
            end
         end
         i2a_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_char_in = i2a_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  rsp_char_in = hex_mode_ff ? i2a_pkg::hex_char(top_digit)
                                            : i2a_pkg::dec_char(top_digit);
                  rsp_last_in = (cnt_ff == i2a_pkg::CNT_W'(1));
                  digits_in   = digits_ff << 4;
                  cnt_in      = cnt_ff - 1'b1;
                  if (cnt_ff == i2a_pkg::CNT_W'(1)) begin
                     state_in = i2a_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = i2a_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
      end
      digits_ff   <= digits_in;
      cnt_ff      <= cnt_in;
      hex_mode_ff <= hex_mode_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/i2a_checker.sv =====
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks for the integer to ascii formatter, bound to the top.
// ----------------------------------------------------------------------------
module i2a_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [i2a_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [i2a_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tlast
);

   // one number at a time: a taken word closes the input for the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready stayed high after a word was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled rsp word changed");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not empty after reset");

   // only digits, uppercase hex letters or the minus sign leave the block
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ((rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
          (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h46) ||
          (rsp_tdata == 8'h2D)))
      else $error("rsp word is not a digit or sign");

   // a minus sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata == 8'h2D) |-> !rsp_tlast)
      else $error("minus sign marked last");

endmodule

bind integer_to_ascii_formatter_unit i2a_checker u_i2a_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the integer to ascii formatter against its own model of the output
// text. Each number taken on req is turned into the expected characters,
// and each character word on rsp is compared with the oldest one waiting.
// Both sides idle at random. Directed numbers cover the extremes, opcode
// three and a back-to-back run first, then random numbers follow.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 64;
   localparam int RANDOM_ITEMS = 126;

   // opcode three has no meaning of its own
   localparam logic [i2a_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [i2a_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } char_word_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [i2a_pkg::REQ_W-1:0]    req_tdata  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [i2a_pkg::RSP_W-1:0]    rsp_tdata;
   logic                         rsp_tlast;

   char_word_type       pending_chars[$];
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count    = 0;
   bit                  no_idle        = 1'b0;

   integer_to_ascii_formatter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin : clock_gen
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // expected text of one number, most significant character first
   task automatic predict_number_text(input logic [i2a_pkg::OPCODE_W-1:0] op,
                                      input logic [i2a_pkg::VALUE_WIDTH-1:0] value);
      logic [i2a_pkg::CHAR_W-1:0]      text[$];
      logic [i2a_pkg::VALUE_WIDTH-1:0] mag;
      logic [3:0]                      nib;
      char_word_type                   w;
      int                              i;
      if (op == i2a_pkg::OP_HEX) begin
         for (i = i2a_pkg::HEX_DIGITS - 1; i >= 0; i--) begin
            nib = value[4*i +: 4];
            text.push_back(nib < 10 ? i2a_pkg::CHAR_ZERO + 7'(nib)
                                    : 7'h41 + 7'(nib - 10));
         end
      end else begin
         // opcode three falls through to the unsigned path
         mag = value;
         if (op == i2a_pkg::OP_SIGNED_DEC && value[i2a_pkg::VALUE_WIDTH-1]) mag = -value;
         do begin
            text.push_front(i2a_pkg::CHAR_ZERO + 7'(mag % 10));
            mag = mag / 10;
         end while (mag != 0);
         if (op == i2a_pkg::OP_SIGNED_DEC && value[i2a_pkg::VALUE_WIDTH-1])
            text.push_front(i2a_pkg::CHAR_MINUS);
      end
      for (i = 0; i < text.size(); i++) begin
         w.ch   = text[i];
         w.last = (i == text.size() - 1);
         pending_chars.push_back(w);
      end
   endtask

   task automatic send_number(input logic [i2a_pkg::OPCODE_W-1:0] op,
                              input logic [i2a_pkg::VALUE_WIDTH-1:0] value);
      logic [i2a_pkg::REQ_W-1:0] word;
      int                        gap;
      word = '0;
      word[i2a_pkg::OPCODE_W-1:0] = op;
      word[i2a_pkg::OPCODE_W +: i2a_pkg::VALUE_WIDTH] = value;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      predict_number_text(op, value);
   endtask

   task automatic check_char_word();
      char_word_type w;
      if (pending_chars.size() == 0) begin
         if (mismatch_count < 10)
            $display("unexpected word: char %h last %b", rsp_tdata, rsp_tlast);
         mismatch_count++;
      end else begin
         w = pending_chars.pop_front();
         if (rsp_tdata !== {1'b0, w.ch} || rsp_tlast !== w.last) begin
            if (mismatch_count < 10)
               $display("mismatch: expected char %h last %b, got %h last %b",
                        {1'b0, w.ch}, w.last, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end
      end
   endtask

   initial begin : rsp_checker
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_char_word();
      end
   end

   task automatic test_hex_extremes();
      send_number(i2a_pkg::OP_HEX, 32'h0000_0000);
      send_number(i2a_pkg::OP_HEX, 32'hFFFF_FFFF);
      send_number(i2a_pkg::OP_HEX, 32'h0123_4567);
      send_number(i2a_pkg::OP_HEX, 32'h89AB_CDEF);
   endtask

   task automatic test_signed_extremes();
      send_number(i2a_pkg::OP_SIGNED_DEC, 32'd0);
      send_number(i2a_pkg::OP_SIGNED_DEC, 32'd1);
      send_number(i2a_pkg::OP_SIGNED_DEC, 32'hFFFF_FFFF);
      send_number(i2a_pkg::OP_SIGNED_DEC, 32'h7FFF_FFFF);
      // most negative value must not overflow
      send_number(i2a_pkg::OP_SIGNED_DEC, 32'h8000_0000);
      send_number(i2a_pkg::OP_SIGNED_DEC, 32'h8000_0001);
      send_number(i2a_pkg::OP_SIGNED_DEC, -32'sd10);
   endtask

   task automatic test_unsigned_extremes();
      send_number(i2a_pkg::OP_UNSIGNED_DEC, 32'd0);
      send_number(i2a_pkg::OP_UNSIGNED_DEC, 32'd9);
      send_number(i2a_pkg::OP_UNSIGNED_DEC, 32'd10);
      send_number(i2a_pkg::OP_UNSIGNED_DEC, 32'hFFFF_FFFF);
      send_number(i2a_pkg::OP_UNSIGNED_DEC, 32'h8000_0000);
      send_number(i2a_pkg::OP_UNSIGNED_DEC, 32'd1000000000);
   endtask

   task automatic test_opcode_three();
      send_number(OP_UNUSED, 32'd0);
      send_number(OP_UNUSED, 32'hFFFF_FFFF);
      send_number(OP_UNUSED, 32'd12345);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      send_number(i2a_pkg::OP_HEX, 32'hDEAD_BEEF);
      send_number(i2a_pkg::OP_SIGNED_DEC, 32'hFFFF_FF85);
      send_number(i2a_pkg::OP_UNSIGNED_DEC, 32'd4000000000);
      send_number(i2a_pkg::OP_HEX, 32'h0000_000A);
      no_idle = 1'b0;
   endtask

   task automatic test_random_numbers();
      logic [i2a_pkg::VALUE_WIDTH-1:0] value;
      logic [i2a_pkg::VALUE_WIDTH-1:0] pow;
      logic [i2a_pkg::OPCODE_W-1:0]    op;
      int                              n;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // a run without idling now and then
         no_idle = (n % 50) >= 40;
         op = ($urandom_range(0, 9) == 0) ? OP_UNUSED
                                          : i2a_pkg::OPCODE_W'($urandom_range(0, 2));
         case ($urandom_range(0, 5))
            0, 1: value = $urandom;
            2:    value = $urandom_range(0, 999);
            3: begin
               pow = 1;
               repeat ($urandom_range(0, 9)) pow = pow * 10;
               value = pow - i2a_pkg::VALUE_WIDTH'($urandom_range(0, 1));
            end
            4:    value = -i2a_pkg::VALUE_WIDTH'($urandom_range(0, 999));
            default: value = i2a_pkg::VALUE_WIDTH'(1)
                             << $urandom_range(0, i2a_pkg::VALUE_WIDTH - 1);
         endcase
         if (op == i2a_pkg::OP_SIGNED_DEC && $urandom_range(0, 3) == 0) value = -value;
         send_number(op, value);
      end
      no_idle = 1'b0;
   endtask

   initial begin : main_sequence
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_hex_extremes();
      test_signed_extremes();
      test_unsigned_extremes();
      test_opcode_three();
      test_back_to_back();
      test_random_numbers();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
